// ----- hdl/iltab_pkg.sv -----
// Shared constants, codes and types for the indexed list table engine.
`default_nettype none

package iltab_pkg;

   // List capacity and the widths that follow from it
   localparam int LIST_DEPTH = 64;
   localparam int ADDR_W     = $clog2(LIST_DEPTH);
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

   // Fixed word field widths
   localparam int INDEX_W  = 6;
   localparam int VALUE_W  = 32;
   localparam int FILL_W   = 7;
   localparam int STATUS_W = 2;
   localparam int KIND_W   = 2;

   // Common width for index/count compares and low-bit extraction
   localparam int WIDE_W = (CNT_W > FILL_W) ? CNT_W : FILL_W;

   typedef enum logic [KIND_W-1:0] {
      REQ_FIND   = 2'd0,
      REQ_MODIFY = 2'd1,
      REQ_APPEND = 2'd2,
      REQ_REMOVE = 2'd3
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_BAD_INDEX = 2'd2,
      STAT_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_MOD_WR,
      ST_REM_CAP,
      ST_REM_MOVE,
      ST_DONE
   } state_type;

   // Control word from the sequencer to the list store
   typedef struct packed {
      logic               wr_en;
      logic [ADDR_W-1:0]  wr_addr;
      logic [VALUE_W-1:0] wr_data;
      logic               rd_en;
      logic [ADDR_W-1:0]  rd_addr;
   } mem_ctrl_type;

endpackage

`default_nettype wire

// ----- hdl/iltab_list.sv -----
// List entry store with registered read port and the shared key comparator.
`default_nettype none

module iltab_list (
   input  wire logic                            clock,
   input  wire iltab_pkg::mem_ctrl_type         ctrl,
   input  wire logic [iltab_pkg::VALUE_W-1:0]   key,
   output logic      [iltab_pkg::VALUE_W-1:0]   rd_data,
   output logic                                 rd_match
);

   logic [iltab_pkg::VALUE_W-1:0] entries_ff [iltab_pkg::LIST_DEPTH];
   logic [iltab_pkg::VALUE_W-1:0] rd_data_ff;

   // one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         entries_ff[ctrl.wr_addr] <= ctrl.wr_data;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= entries_ff[ctrl.rd_addr];
      end
   end

   // equality compare against the search key
   assign rd_data  = rd_data_ff;
   assign rd_match = (rd_data_ff == key);

endmodule

`default_nettype wire

// ----- hdl/indexed_list_table_engine.sv -----
// Top level: request sequencer, fill count and result register of the list engine.
//
//   channel | direction | ports                                      | handshake
//   req     | in        | req_type, req_entry_index, req_entry_value | req_valid / req_stall
//   rsp     | out       | rsp_status, rsp_found_index,               | rsp_valid / rsp_stall
//           |           | rsp_old_value, rsp_fill_count              |
//
// One request at a time; the list memory's single read port sets the pace.
// Append writes at once; modify reads, then overwrites in place; find scans the
// entries up to the hit; remove shifts the entries above the index down one place.
// Synchronous reset empties the list; entry contents are not cleared.
// A stalled result holds in the output register; the next request is taken
// meanwhile and waits in its final step until the register frees up.
`default_nettype none

module indexed_list_table_engine (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // request channel
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic        [iltab_pkg::KIND_W-1:0]    req_type,
   input  wire logic        [iltab_pkg::INDEX_W-1:0]   req_entry_index,
   input  wire logic signed [iltab_pkg::VALUE_W-1:0]   req_entry_value,
   // response channel
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic             [iltab_pkg::STATUS_W-1:0]  rsp_status,
   output logic             [iltab_pkg::INDEX_W-1:0]   rsp_found_index,
   output logic signed      [iltab_pkg::VALUE_W-1:0]   rsp_old_value,
   output logic             [iltab_pkg::FILL_W-1:0]    rsp_fill_count
);

   localparam int CW = iltab_pkg::CNT_W;
   localparam int AW = iltab_pkg::ADDR_W;
   localparam int WW = iltab_pkg::WIDE_W;
   localparam int VW = iltab_pkg::VALUE_W;
   localparam int IW = iltab_pkg::INDEX_W;
   localparam int FW = iltab_pkg::FILL_W;

   iltab_pkg::state_type    state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           ptr_ff, ptr_in;
   logic                    chk_ff, chk_in;
   logic [VW-1:0]           key_ff, key_in;
   iltab_pkg::status_type   res_status_ff, res_status_in;
   logic [IW-1:0]           res_found_ff, res_found_in;
   logic [VW-1:0]           res_old_ff, res_old_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;
   logic [IW-1:0]           rsp_found_ff, rsp_found_in;
   logic [VW-1:0]           rsp_old_ff, rsp_old_in;
   logic [FW-1:0]           rsp_fill_ff, rsp_fill_in;

   iltab_pkg::mem_ctrl_type mem_ctrl;
   logic [VW-1:0]           rd_data;
   logic                    rd_match;

   logic                    accept;
   logic                    out_free;
   logic [WW-1:0]           idx_wide;
   logic                    idx_ok;
   logic [CW-1:0]           ptr_next;
   logic [CW-1:0]           ptr_next2;
   logic [WW-1:0]           hit_wide;

   iltab_list u_list (
      .clock    (clock),
      .ctrl     (mem_ctrl),
      .key      (key_ff),
      .rd_data  (rd_data),
      .rd_match (rd_match)
   );

   // handshake and shared helpers
   assign req_stall = (state_ff != iltab_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign idx_wide  = WW'(req_entry_index);
   assign idx_ok    = (idx_wide < WW'(count_ff));
   assign ptr_next  = CW'(ptr_ff + CW'(1));
   assign ptr_next2 = CW'(ptr_ff + CW'(2));
   assign hit_wide  = WW'(CW'(ptr_ff - CW'(1)));

   // sequencer: next state, memory control and result building
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      chk_in        = chk_ff;
      key_in        = key_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_old_in    = res_old_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_old_in    = rsp_old_ff;
      rsp_fill_in   = rsp_fill_ff;
      mem_ctrl      = '0;

      unique case (state_ff)
         iltab_pkg::ST_IDLE: begin
            if (accept) begin
               key_in        = req_entry_value;
               res_found_in  = '0;
               res_old_in    = '0;
               res_status_in = iltab_pkg::STAT_OK;
               unique case (iltab_pkg::req_kind_type'(req_type))
                  iltab_pkg::REQ_FIND: begin
                     ptr_in   = '0;
                     chk_in   = 1'b0;
                     state_in = iltab_pkg::ST_FIND;
                  end
                  iltab_pkg::REQ_MODIFY: begin
                     if (idx_ok) begin
                        mem_ctrl.rd_en   = 1'b1;
                        mem_ctrl.rd_addr = idx_wide[AW-1:0];
                        ptr_in           = CW'(idx_wide);
                        state_in         = iltab_pkg::ST_MOD_WR;
                     end else begin
                        res_status_in = iltab_pkg::STAT_BAD_INDEX;
                        state_in      = iltab_pkg::ST_DONE;
                     end
                  end
                  iltab_pkg::REQ_APPEND: begin
                     if (count_ff < CW'(iltab_pkg::LIST_DEPTH)) begin
                        mem_ctrl.wr_en   = 1'b1;
                        mem_ctrl.wr_addr = count_ff[AW-1:0];
                        mem_ctrl.wr_data = req_entry_value;
                        count_in         = CW'(count_ff + CW'(1));
                     end else begin
                        res_status_in = iltab_pkg::STAT_FULL;
                     end
                     state_in = iltab_pkg::ST_DONE;
                  end
                  iltab_pkg::REQ_REMOVE: begin
                     if (idx_ok) begin
                        mem_ctrl.rd_en   = 1'b1;
                        mem_ctrl.rd_addr = idx_wide[AW-1:0];
                        ptr_in           = CW'(idx_wide);
                        state_in         = iltab_pkg::ST_REM_CAP;
                     end else begin
                        res_status_in = iltab_pkg::STAT_BAD_INDEX;
                        state_in      = iltab_pkg::ST_DONE;
                     end
                  end
                  default: begin
                     state_in = iltab_pkg::ST_IDLE;
                  end
               endcase
            end
         end

         // walk: read one entry per cycle, check the one read last cycle
         iltab_pkg::ST_FIND: begin
            priority if (chk_ff && rd_match) begin
               res_status_in = iltab_pkg::STAT_OK;
               res_found_in  = hit_wide[IW-1:0];
               chk_in        = 1'b0;
               state_in      = iltab_pkg::ST_DONE;
            end else if (ptr_ff < count_ff) begin
               mem_ctrl.rd_en   = 1'b1;
               mem_ctrl.rd_addr = ptr_ff[AW-1:0];
               ptr_in           = ptr_next;
               chk_in           = 1'b1;
            end else begin
               res_status_in = iltab_pkg::STAT_NOT_FOUND;
               chk_in        = 1'b0;
               state_in      = iltab_pkg::ST_DONE;
            end
         end

         // old value is back; overwrite in place
         iltab_pkg::ST_MOD_WR: begin
            res_old_in       = rd_data;
            mem_ctrl.wr_en   = 1'b1;
            mem_ctrl.wr_addr = ptr_ff[AW-1:0];
            mem_ctrl.wr_data = key_ff;
            state_in         = iltab_pkg::ST_DONE;
         end

         // capture removed value, start the shift if entries follow
         iltab_pkg::ST_REM_CAP: begin
            res_old_in = rd_data;
            if (ptr_next < count_ff) begin
               mem_ctrl.rd_en   = 1'b1;
               mem_ctrl.rd_addr = ptr_next[AW-1:0];
               state_in         = iltab_pkg::ST_REM_MOVE;
            end else begin
               count_in = CW'(count_ff - CW'(1));
               state_in = iltab_pkg::ST_DONE;
            end
         end

         // move entry ptr+1 down to ptr, prefetch the next one
         iltab_pkg::ST_REM_MOVE: begin
            mem_ctrl.wr_en   = 1'b1;
            mem_ctrl.wr_addr = ptr_ff[AW-1:0];
            mem_ctrl.wr_data = rd_data;
            ptr_in           = ptr_next;
            if (ptr_next2 < count_ff) begin
               mem_ctrl.rd_en   = 1'b1;
               mem_ctrl.rd_addr = ptr_next2[AW-1:0];
            end else begin
               count_in = CW'(count_ff - CW'(1));
               state_in = iltab_pkg::ST_DONE;
            end
         end

         // hand the word to the output register once it is free
         iltab_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_found_in  = res_found_ff;
               rsp_old_in    = res_old_ff;
               rsp_fill_in   = FW'(WW'(count_ff));
               state_in      = iltab_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = iltab_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= iltab_pkg::ST_IDLE;
         count_ff     <= '0;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      key_ff        <= key_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_old_ff    <= res_old_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_old_ff    <= rsp_old_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_index = rsp_found_ff;
   assign rsp_old_value   = rsp_old_ff;
   assign rsp_fill_count  = rsp_fill_ff;

`ifndef NO_ASSERTIONS
   // fill count stays within capacity
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(iltab_pkg::LIST_DEPTH))
      else $error("fill count above capacity");

   // fill count moves by at most one per cycle
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff))) |->
         ((count_ff == CW'($past(count_ff) + CW'(1))) ||
          (count_ff == CW'($past(count_ff) - CW'(1)))))
      else $error("fill count jumped");

   // an accepted request always leaves idle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != iltab_pkg::ST_IDLE))
      else $error("request accepted without starting work");

   // a new response only comes from the final step
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> ($past(state_ff) == iltab_pkg::ST_DONE))
      else $error("response raised outside final step");
`endif

endmodule

`default_nettype wire

// ----- test/tb_indexed_list_table_engine.sv -----
// Self-checking testbench for the indexed list table engine: directed and random list requests.
`default_nettype none

module tb_indexed_list_table_engine;

   localparam int CLK_PERIOD     = 10;
   localparam int TIMEOUT_CYCLES = 1_000_000;
   localparam int DRAIN_CYCLES   = 100;
   localparam int PHASE_WORDS    = 150;
   localparam int PHASE_COUNT    = 13;
   localparam int REPORT_LIMIT   = 10;

   localparam int IW    = iltab_pkg::INDEX_W;
   localparam int VW    = iltab_pkg::VALUE_W;
   localparam int FW    = iltab_pkg::FILL_W;
   localparam int SW    = iltab_pkg::STATUS_W;
   localparam int KW    = iltab_pkg::KIND_W;
   localparam int DEPTH = iltab_pkg::LIST_DEPTH;

   // Request mixes for the random phases
   typedef enum int {MIX_FILL, MIX_EVEN, MIX_DRAIN} mix_type;

   // One expected result word
   typedef struct {
      iltab_pkg::status_type status;
      logic [IW-1:0]         found_index;
      logic signed [VW-1:0]  old_value;
      logic [FW-1:0]         fill_count;
   } list_outcome_type;

   // Shadow copy of the list plus the queue of results still owed by the block
   class list_scoreboard;
      logic signed [VW-1:0] entries [DEPTH];
      int                   count;
      list_outcome_type     pending [$];
      int                   failures;

      function new();
         count    = 0;
         failures = 0;
      endfunction

      function void report(string msg);
         failures++;
         if (failures <= REPORT_LIMIT)
            $display("MISMATCH at %0t: %s", $realtime, msg);
      endfunction

      // Apply one accepted request to the shadow list and queue its result
      function void note_request(iltab_pkg::req_kind_type kind, logic [IW-1:0] idx,
                                 logic signed [VW-1:0] val);
         list_outcome_type res;
         res.status      = iltab_pkg::STAT_OK;
         res.found_index = '0;
         res.old_value   = '0;
         case (kind)
            iltab_pkg::REQ_FIND: begin
               res.status = iltab_pkg::STAT_NOT_FOUND;
               for (int i = 0; i < count; i++) begin
                  if (entries[i] == val) begin
                     res.status      = iltab_pkg::STAT_OK;
                     res.found_index = IW'(i);
                     break;
                  end
               end
            end
            iltab_pkg::REQ_MODIFY: begin
               if (int'(idx) < count) begin
                  res.old_value = entries[idx];
                  entries[idx]  = val;
               end else begin
                  res.status = iltab_pkg::STAT_BAD_INDEX;
               end
            end
            iltab_pkg::REQ_APPEND: begin
               if (count < DEPTH) begin
                  entries[count] = val;
                  count++;
               end else begin
                  res.status = iltab_pkg::STAT_FULL;
               end
            end
            iltab_pkg::REQ_REMOVE: begin
               if (int'(idx) < count) begin
                  res.old_value = entries[idx];
                  for (int i = int'(idx); i + 1 < count; i++)
                     entries[i] = entries[i + 1];
                  count--;
               end else begin
                  res.status = iltab_pkg::STAT_BAD_INDEX;
               end
            end
         endcase
         res.fill_count = FW'(count);
         pending.push_back(res);
      endfunction

      // Compare one accepted result word with the oldest expectation
      function void check_result(logic [SW-1:0] status, logic [IW-1:0] found,
                                 logic signed [VW-1:0] old, logic [FW-1:0] fill);
         list_outcome_type want;
         if (pending.size() == 0) begin
            report($sformatf("unexpected word status=%0d found=%0d old=%0d fill=%0d",
                             status, found, old, fill));
            return;
         end
         want = pending.pop_front();
         if (status !== want.status || found !== want.found_index ||
             old !== want.old_value || fill !== want.fill_count)
            report($sformatf({"status exp %0d got %0d, found exp %0d got %0d, ",
                              "old exp %0d got %0d, fill exp %0d got %0d"},
                             want.status, status, want.found_index, found,
                             want.old_value, old, want.fill_count, fill));
      endfunction
   endclass

   logic                  clock           = 1'b0;
   logic                  reset           = 1'b1;
   logic                  req_valid       = 1'b0;
   logic                  req_stall;
   logic [KW-1:0]         req_type        = '0;
   logic [IW-1:0]         req_entry_index = '0;
   logic signed [VW-1:0]  req_entry_value = '0;
   logic                  rsp_valid;
   logic                  rsp_stall       = 1'b0;
   logic [SW-1:0]         rsp_status;
   logic [IW-1:0]         rsp_found_index;
   logic signed [VW-1:0]  rsp_old_value;
   logic [FW-1:0]         rsp_fill_count;

   list_scoreboard sb;
   bit             idle_on = 1'b1;

   indexed_list_table_engine DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_found_index (rsp_found_index),
      .rsp_old_value   (rsp_old_value),
      .rsp_fill_count  (rsp_fill_count)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Send one request word; entered and left at a falling edge
   task automatic send_word(iltab_pkg::req_kind_type kind, logic [IW-1:0] idx,
                            logic signed [VW-1:0] val);
      int gap;
      gap = idle_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_entry_index <= idx;
      req_entry_value <= val;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_request(kind, idx, val);
      @(negedge clock);
   endtask

   // Drop valid and hold off until every owed result word has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
   endtask

   // Values: a small pool for duplicates, the extremes, or anything
   function automatic logic signed [VW-1:0] pick_value();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 25)
         return VW'($urandom_range(0, 7)) - 4;
      if (pick < 35) begin
         case ($urandom_range(0, 3))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'sh0;
            default: return -32'sd1;
         endcase
      end
      return $urandom;
   endfunction

   // One random request, weighted by mix; mostly valid indexes and live keys
   task automatic random_word(mix_type mix);
      int                      pick;
      int                      cut_app;
      int                      cut_find;
      int                      cut_mod;
      iltab_pkg::req_kind_type kind;
      logic [IW-1:0]           idx;
      logic signed [VW-1:0]    val;
      pick = $urandom_range(0, 99);
      case (mix)
         MIX_FILL: begin
            cut_app  = 70;
            cut_find = 85;
            cut_mod  = 95;
         end
         MIX_DRAIN: begin
            cut_app  = 15;
            cut_find = 35;
            cut_mod  = 50;
         end
         default: begin
            cut_app  = 25;
            cut_find = 50;
            cut_mod  = 75;
         end
      endcase
      if (pick < cut_app)
         kind = iltab_pkg::REQ_APPEND;
      else if (pick < cut_find)
         kind = iltab_pkg::REQ_FIND;
      else if (pick < cut_mod)
         kind = iltab_pkg::REQ_MODIFY;
      else
         kind = iltab_pkg::REQ_REMOVE;
      if (sb.count > 0 && $urandom_range(0, 9) < 8)
         idx = IW'($urandom_range(0, sb.count - 1));
      else
         idx = IW'($urandom_range(0, 63));
      val = pick_value();
      if (kind == iltab_pkg::REQ_FIND && sb.count > 0 && $urandom_range(0, 9) < 7)
         val = sb.entries[$urandom_range(0, sb.count - 1)];
      send_word(kind, idx, val);
   endtask

   // Receiver: random stall per word, check every accepted word
   initial begin : rsp_side
      int hold;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         hold = idle_on ? $urandom_range(0, 8) : 0;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0));
         sb.check_result(rsp_status, rsp_found_index, rsp_old_value, rsp_fill_count);
         @(negedge clock);
      end
   end

   // Main sequence
   initial begin : stim
      mix_type mix;
      sb = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty list: find misses, modify and remove flag bad index
      send_word(iltab_pkg::REQ_FIND,   6'd0,  32'sd0);
      send_word(iltab_pkg::REQ_MODIFY, 6'd0,  32'sd5);
      send_word(iltab_pkg::REQ_REMOVE, 6'd63, 32'sd0);
      // Extreme values, with a duplicate to check lowest-index find
      send_word(iltab_pkg::REQ_APPEND, 6'd63, 32'sh8000_0000);
      send_word(iltab_pkg::REQ_APPEND, 6'd0,  32'sh7FFF_FFFF);
      send_word(iltab_pkg::REQ_APPEND, 6'd0,  32'sh0);
      send_word(iltab_pkg::REQ_APPEND, 6'd0,  -32'sd1);
      send_word(iltab_pkg::REQ_APPEND, 6'd0,  32'sh7FFF_FFFF);
      send_word(iltab_pkg::REQ_FIND,   6'd0,  32'sh7FFF_FFFF);
      send_word(iltab_pkg::REQ_FIND,   6'd0,  32'sh8000_0000);
      send_word(iltab_pkg::REQ_FIND,   6'd0,  -32'sd1);
      send_word(iltab_pkg::REQ_FIND,   6'd0,  32'sd12345);
      // Modify in range, at the fill count and at the top index
      send_word(iltab_pkg::REQ_MODIFY, 6'd2,  32'sh5555_5555);
      send_word(iltab_pkg::REQ_MODIFY, 6'd5,  32'sd1);
      send_word(iltab_pkg::REQ_MODIFY, 6'd63, 32'sd1);
      // Remove last and first, then a stale index, then empty it
      send_word(iltab_pkg::REQ_REMOVE, 6'd4,  32'sd0);
      send_word(iltab_pkg::REQ_REMOVE, 6'd0,  32'sd0);
      send_word(iltab_pkg::REQ_FIND,   6'd0,  32'sh7FFF_FFFF);
      send_word(iltab_pkg::REQ_REMOVE, 6'd3,  32'sd0);
      send_word(iltab_pkg::REQ_REMOVE, 6'd0,  32'sd0);
      send_word(iltab_pkg::REQ_REMOVE, 6'd0,  32'sd0);
      send_word(iltab_pkg::REQ_REMOVE, 6'd0,  32'sd0);
      send_word(iltab_pkg::REQ_FIND,   6'd0,  -32'sd1);
      wait_drained();

      // Random phases: fill to capacity, mixed traffic, drain; some with no idling
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p % 3)
            0:       mix = MIX_FILL;
            1:       mix = MIX_EVEN;
            default: mix = MIX_DRAIN;
         endcase
         idle_on = (p % 4 != 3);
         for (int k = 0; k < PHASE_WORDS; k++)
            random_word(mix);
         wait_drained();
      end

      idle_on = 1'b1;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // Watchdog
   initial begin : watchdog
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire
